[hdl/vdn_pkg.sv]
// vdn_pkg: shared types, mode codes and default sizes for the vector distance/dot/norm block
// no dependencies; imported by every module under hdl/
package vdn_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ACC_WIDTH_DEF   = 64;
	localparam int IN_WIDTH        = 32;
	localparam int RESULT_WIDTH    = 64;
	localparam int MODE_WIDTH      = 2;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [MODE_WIDTH-1:0] MODE_EUCLID = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_DOT    = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_NORM   = 2'd2;

	typedef struct packed {
		logic is_norm;
		logic is_dot;
	} mode_kind_t;

	// tag that travels with a finished sum
	typedef struct packed {
		logic clip;
		logic is_dot;
	} sum_tag_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROOT,
		BK_HOLD
	} back_state_t;

	function automatic mode_kind_t decode_mode(input logic [MODE_WIDTH-1:0] m);
		mode_kind_t k;
		unique case (m)
			MODE_EUCLID: k = '{is_norm: 1'b0, is_dot: 1'b0};
			MODE_DOT:    k = '{is_norm: 1'b0, is_dot: 1'b1};
			MODE_NORM:   k = '{is_norm: 1'b1, is_dot: 1'b0};
			// unused code behaves as norm
			default:     k = '{is_norm: 1'b1, is_dot: 1'b0};
		endcase
		return k;
	endfunction

endpackage

[hdl/vdn_front.sv]
// vdn_front: operand select, registered multiply and saturating accumulate
// depends on vdn_pkg; emits one finished sum per last-marked request
module vdn_front import vdn_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [MODE_WIDTH-1:0] mode,
	input  logic                  push,
	output logic                  full,
	input  logic [IN_WIDTH-1:0]   coord_a,
	input  logic [IN_WIDTH-1:0]   coord_b,
	input  logic                  last,
	input  logic                  q_full,
	output logic                  sum_valid,
	output logic [ACC_WIDTH-1:0]  sum_acc,
	output sum_tag_t              sum_tag
);

	localparam int OPW = COORD_WIDTH + 1;
	localparam int PW  = 2 * OPW;
	localparam int TW  = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	mode_kind_t             kind;
	logic signed [OPW-1:0]  sa, sb, dab, dba, x_in, y_in;
	logic                   accept, commit, adv_s1;

	logic                   v_s1, last_s1, dot_s1;
	logic signed [OPW-1:0]  x_s1, y_s1;
	logic                   v_s2, last_s2, dot_s2;
	logic signed [PW-1:0]   p_s2;

	logic signed [ACC_WIDTH-1:0] acc_q;
	logic                        clip_q;

	logic signed [TW-1:0]        term_ext;
	logic                        term_hi, term_lo;
	logic signed [ACC_WIDTH-1:0] term;
	logic signed [ACC_WIDTH:0]   sum;
	logic                        ovf;
	logic signed [ACC_WIDTH-1:0] acc_n;
	logic                        clip_n;

	always_comb begin
		kind = decode_mode(mode);
		sa   = OPW'(signed'(coord_a[COORD_WIDTH-1:0]));
		sb   = OPW'(signed'(coord_b[COORD_WIDTH-1:0]));
		dab  = sa - sb;
		dba  = sb - sa;
		priority if (kind.is_norm) begin
			x_in = sa;
			y_in = sa;
		end else if (kind.is_dot) begin
			x_in = sa;
			y_in = sb;
		end else begin
			// square of |a-b|, magnitude always fits the COORD_WIDTH+1 bit operand
			x_in = dab[OPW-1] ? dba : dab;
			y_in = dab[OPW-1] ? dba : dab;
		end
	end

	assign commit = v_s2 && (!last_s2 || !q_full);
	assign adv_s1 = v_s1 && (!v_s2 || commit);
	assign full   = v_s1 && !(!v_s2 || commit);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;
			if (adv_s1)
				v_s2 <= 1'b1;
			else if (commit)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_in;
			y_s1    <= y_in;
			last_s1 <= last;
			dot_s1  <= kind.is_dot;
		end
		if (adv_s1) begin
			p_s2    <= PW'(x_s1) * PW'(y_s1);
			last_s2 <= last_s1;
			dot_s2  <= dot_s1;
		end
	end

	// clip the term, then saturating add
	always_comb begin
		term_ext = TW'(p_s2);
		term_hi  = term_ext > TW'(ACC_MAX);
		term_lo  = term_ext < TW'(ACC_MIN);
		priority if (term_hi)
			term = ACC_MAX;
		else if (term_lo)
			term = ACC_MIN;
		else
			term = ACC_WIDTH'(term_ext);
		sum = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(term);
		ovf = sum[ACC_WIDTH] != sum[ACC_WIDTH-1];
		if (ovf)
			acc_n = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		else
			acc_n = sum[ACC_WIDTH-1:0];
		clip_n = clip_q || term_hi || term_lo || ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else if (commit) begin
			if (last_s2) begin
				acc_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				acc_q  <= acc_n;
				clip_q <= clip_n;
			end
		end
	end

	assign sum_valid      = commit && last_s2;
	assign sum_acc        = acc_n;
	assign sum_tag.clip   = clip_n;
	assign sum_tag.is_dot = dot_s2;

endmodule

[hdl/vdn_fifo.sv]
// vdn_fifo: small register queue between the accumulate front and the root back end
// depends on vdn_pkg for the default width and depth
module vdn_fifo import vdn_pkg::*; #(
	parameter int WIDTH = ACC_WIDTH_DEF + $bits(sum_tag_t),
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             q_full,
	output logic             q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign q_full  = cnt_q == CNT_W'(DEPTH);
	assign q_empty = cnt_q == '0;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= next_ptr(wp_q);
			if (rd)
				rp_q <= next_ptr(rp_q);
			if (wr && !rd)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (rd && !wr)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

[hdl/vdn_back.sv]
// vdn_back: bit-serial integer square root and the result output register
// depends on vdn_pkg; takes sums from vdn_fifo
module vdn_back import vdn_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  logic [ACC_WIDTH-1:0]    q_acc,
	input  sum_tag_t                q_tag,
	output logic                    q_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic [RESULT_WIDTH-1:0] result,
	output logic                    saturated
);

	localparam int STEPS = ACC_WIDTH / 2;
	localparam int RADW  = 2 * STEPS;
	localparam int REMW  = STEPS + 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	back_state_t state_q, state_d;
	logic        load_out, pos;

	logic [RADW-1:0]         rad_q;
	logic [REMW-1:0]         rem_q, rem_sh, trial, rem_n;
	logic [STEPS-1:0]        root_q, root_n;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ge;
	logic [RESULT_WIDTH-1:0] res_q, result_q;
	logic                    sat_q, saturated_q, out_v_q;

	assign pos = !q_acc[ACC_WIDTH-1] && (q_acc != '0);

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_tag.is_dot || !pos)
						state_d = BK_HOLD;
					else
						state_d = BK_ROOT;
				end
			end
			BK_ROOT: begin
				if (cnt_q == CNT_W'(1))
					state_d = BK_HOLD;
			end
			BK_HOLD: begin
				if (!out_v_q || pop) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// one root bit per cycle, two radicand bits shifted in
	always_comb begin
		rem_sh = {rem_q[STEPS-1:0], rad_q[RADW-1:RADW-2]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_n  = ge ? rem_sh - trial : rem_sh;
		root_n = {root_q[STEPS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop)
				cnt_q <= CNT_W'(STEPS);
			else if (state_q == BK_ROOT)
				cnt_q <= cnt_q - CNT_W'(1);
			if (load_out)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sat_q  <= q_tag.clip;
			res_q  <= q_tag.is_dot ? RESULT_WIDTH'(signed'(q_acc)) : '0;
			rad_q  <= q_acc[RADW-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == BK_ROOT) begin
			rad_q  <= {rad_q[RADW-3:0], 2'b00};
			rem_q  <= rem_n;
			root_q <= root_n;
			if (cnt_q == CNT_W'(1))
				res_q <= RESULT_WIDTH'(root_n);
		end
		if (load_out) begin
			result_q    <= res_q;
			saturated_q <= sat_q;
		end
	end

	assign empty     = !out_v_q;
	assign result    = result_q;
	assign saturated = saturated_q;

endmodule

[hdl/vector_distance_dot_norm.sv]
// vector_distance_dot_norm: top level, mode register, front/queue/back wiring
// depends on vdn_pkg, vdn_front, vdn_fifo, vdn_back
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------
// elements  | in        | push / full        | coord_a, coord_b, last
// results   | out       | empty / pop        | result, saturated
// mode reg  | in        | mode_we            | mode_wdata
//
// one element accepted per cycle while full is low; multiply and accumulate take two stages
// a dot result passes from the accumulator through the sum queue to the output register; a root
// result also passes the root unit, which resolves one bit per cycle
// in root modes the back end pops the next sum only after the current result is loaded
// reset clears the pipeline, accumulator, queue and output; mode resets to distance
// full rises only when the sum queue is full and a last element waits to commit
module vector_distance_dot_norm import vdn_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    mode_we,
	input  logic [MODE_WIDTH-1:0]   mode_wdata,
	input  logic                    push,
	output logic                    full,
	input  logic [IN_WIDTH-1:0]     coord_a,
	input  logic [IN_WIDTH-1:0]     coord_b,
	input  logic                    last,
	output logic                    empty,
	input  logic                    pop,
	output logic [RESULT_WIDTH-1:0] result,
	output logic                    saturated
);

	localparam int QW = ACC_WIDTH + $bits(sum_tag_t);

	logic [MODE_WIDTH-1:0] mode_q;
	logic                  sum_valid, q_full, q_empty, q_pop;
	logic [ACC_WIDTH-1:0]  sum_acc, q_acc;
	sum_tag_t              sum_tag, q_tag;
	logic [QW-1:0]         q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_EUCLID;
		else if (mode_we)
			mode_q <= mode_wdata;
	end

	vdn_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.push     (push),
		.full     (full),
		.coord_a  (coord_a),
		.coord_b  (coord_b),
		.last     (last),
		.q_full   (q_full),
		.sum_valid(sum_valid),
		.sum_acc  (sum_acc),
		.sum_tag  (sum_tag)
	);

	vdn_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (sum_valid),
		.wdata  ({sum_tag, sum_acc}),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	assign q_tag = q_rdata[QW-1:ACC_WIDTH];
	assign q_acc = q_rdata[ACC_WIDTH-1:0];

	vdn_back #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_acc    (q_acc),
		.q_tag    (q_tag),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.saturated(saturated)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> !q_full)
		else $error("finished sum pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("root unit popped an empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |=> !q_empty)
		else $error("queue empty right after a push");

endmodule
